[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(expr), msg)

`endif

[hw/rtl/buc_pkg.sv]
// shared types, field widths and codes of the bilinear integer upscaler
// no dependencies
package buc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_SCALE  = 16;

	localparam int PIX_W       = 8;
	localparam int SRC_W       = 8;
	localparam int COORD_W     = 12;
	localparam int IN_DATA_W   = 48;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int SCALE_CFG_W = 5;
	localparam int DIM_CFG_W   = 9;
	localparam int PIX_MAX     = 255;

	localparam int RST_SCALE  = 2;
	localparam int RST_WIDTH  = 256;
	localparam int RST_HEIGHT = 256;

	localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_x;
		logic [PIX_W-1:0]   pixel_in;
		logic [SRC_W-1:0]   src_y;
		logic [SRC_W-1:0]   src_x;
	} in_pl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_READ,
		ST_NORM,
		ST_DONE
	} buc_state_t;

endpackage

[hw/rtl/bilinear_integer_upscaler.sv]
// Bilinear integer upscaler. A load transfer (tuser = 0) writes one 8-bit pixel into the
// source image store, and loads stream at one per clock while no query occupies the block.
// A query transfer (tuser = 1) returns one result: out_of_range with a zero pixel when the
// point lies outside width*scale by height*scale, otherwise the floored bilinear
// blend of the four neighbouring source pixels, right and bottom clamped at the image edge.
// An in-range query occupies the block for serial division of the coordinates by scale,
// four reads through the single read port of the store, and a serial division by scale
// squared. The next transfer is taken as soon as the result is in the output register,
// even if that result has not yet been collected. Reading a pixel never loaded is undefined.
// Depends on buc_pkg, buc_ram and buc_div.
module bilinear_integer_upscaler #(
	parameter int MAX_WIDTH  = buc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = buc_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_SCALE  = buc_pkg::DEF_MAX_SCALE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [buc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [buc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// src_x, src_y, pixel_in, out_x, out_y
	input  logic [buc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// pixel_out
	output logic [buc_pkg::PIX_W-1:0]      m_axis_tdata,
	// out_of_range
	output logic                            m_axis_tuser
);

	import buc_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int SW    = $clog2(MAX_SCALE + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PVW   = PIX_W + SW;
	localparam int SQW   = 2 * SW;
	localparam int ACCW  = PIX_W + 2 * SW;
	localparam int LXW   = WW + SW;
	localparam int LYW   = HW + SW;
	localparam int CXW   = (LXW > COORD_W) ? LXW : COORD_W;
	localparam int CYW   = (LYW > COORD_W) ? LYW : COORD_W;

	localparam int SCALE_RST  = (RST_SCALE > MAX_SCALE) ? MAX_SCALE : RST_SCALE;
	localparam int WIDTH_RST  = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int HEIGHT_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	// configuration
	logic [SW-1:0]          scale_q;
	logic [WW-1:0]          width_q;
	logic [HW-1:0]          height_q;
	logic [SCALE_CFG_W-1:0] cfg_s;
	logic [DIM_CFG_W-1:0]   cfg_d;
	logic [SW-1:0]          scale_sat;
	logic [WW-1:0]          width_sat;
	logic [HW-1:0]          height_sat;

	assign cfg_s = cfg_wdata[SCALE_CFG_W-1:0];
	assign cfg_d = cfg_wdata[DIM_CFG_W-1:0];

	always_comb begin
		if (cfg_s == '0) begin
			scale_sat = SW'(1);
		end else if (int'(cfg_s) > MAX_SCALE) begin
			scale_sat = SW'(MAX_SCALE);
		end else begin
			scale_sat = SW'(cfg_s);
		end
		if (cfg_d == '0) begin
			width_sat  = WW'(1);
			height_sat = HW'(1);
		end else begin
			width_sat  = (int'(cfg_d) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_d);
			height_sat = (int'(cfg_d) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SW'(SCALE_RST);
			width_q  <= WW'(WIDTH_RST);
			height_q <= HW'(HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SCALE:  scale_q  <= scale_sat;
				REG_WIDTH:  width_q  <= width_sat;
				REG_HEIGHT: height_q <= height_sat;
				default: ;
			endcase
		end
	end

	// input side
	in_pl_t in_pl;
	logic   in_xfer;
	logic   ld_we;
	logic [AW-1:0] ld_addr;

	assign in_pl   = in_pl_t'(s_axis_tdata);
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign ld_we   = in_xfer && (s_axis_tuser == ACT_LOAD)
		&& (int'(in_pl.src_x) < MAX_WIDTH) && (int'(in_pl.src_y) < MAX_HEIGHT);
	assign ld_addr = AW'(AW'(in_pl.src_y) * AW'(MAX_WIDTH) + AW'(in_pl.src_x));

	// control
	buc_state_t state_q, state_d;
	logic       xy_start;
	logic       norm_start;
	logic       issue;
	logic       out_free;
	logic       x_busy, y_busy, n_busy;
	logic       oor;
	logic [2:0] rd_cnt_q;
	logic       valid_s1, valid_s2;
	logic       out_valid_q;

	// query datapath
	logic [COORD_W-1:0] ox_q, oy_q;
	logic [LXW-1:0]     lim_x;
	logic [LYW-1:0]     lim_y;
	logic [SQW-1:0]     sq_q;
	logic [COORD_W-1:0] x_quo, y_quo;
	logic [SW-1:0]      x_rem, y_rem;
	logic [ACCW-1:0]    n_quo;
	logic [XW-1:0]      px, kx;
	logic [YW-1:0]      py, ky;
	logic [WW-1:0]      px_inc;
	logic [HW-1:0]      py_inc;
	logic [XW-1:0]      px_q, kx_q;
	logic [YW-1:0]      py_q, ky_q;
	logic [SW-1:0]      wx0_q, wx1_q, wy0_q, wy1_q;
	logic [XW-1:0]      rd_x;
	logic [YW-1:0]      rd_y;
	logic [AW-1:0]      rd_addr;
	logic [PIX_W-1:0]   rd_data;
	logic [1:0]         k_s1, k_s2;
	logic [PVW-1:0]     pv_s2;
	logic [ACCW-1:0]    acc_q;
	logic [PIX_W-1:0]   res_pix_q;
	logic               res_oor_q;
	logic [PIX_W-1:0]   out_pix_q;
	logic               out_oor_q;

	assign lim_x  = LXW'(width_q) * LXW'(scale_q);
	assign lim_y  = LYW'(height_q) * LYW'(scale_q);
	assign oor    = (CXW'(ox_q) >= CXW'(lim_x)) || (CYW'(oy_q) >= CYW'(lim_y));
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		xy_start   = 1'b0;
		norm_start = 1'b0;
		issue      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (s_axis_tuser == ACT_QUERY)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (oor) begin
					state_d = ST_DONE;
				end else begin
					xy_start = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!x_busy && !y_busy) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				issue = !rd_cnt_q[2];
				if (rd_cnt_q[2] && !valid_s1 && !valid_s2) begin
					norm_start = 1'b1;
					state_d    = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!n_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	buc_div #(.NUM_W(COORD_W), .DEN_W(SW)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xy_start),
		.num    (ox_q),
		.den    (scale_q),
		.busy   (x_busy),
		.quo    (x_quo),
		.rem    (x_rem)
	);

	buc_div #(.NUM_W(COORD_W), .DEN_W(SW)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (xy_start),
		.num    (oy_q),
		.den    (scale_q),
		.busy   (y_busy),
		.quo    (y_quo),
		.rem    (y_rem)
	);

	buc_div #(.NUM_W(ACCW), .DEN_W(SQW)) u_div_n (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.num    (acc_q),
		.den    (sq_q),
		.busy   (n_busy),
		.quo    (n_quo),
		.rem    ()
	);

	// neighbour columns and rows, clamped at the last column and row
	assign px     = XW'(x_quo);
	assign py     = YW'(y_quo);
	assign px_inc = WW'(px) + WW'(1);
	assign py_inc = HW'(py) + HW'(1);
	assign kx     = (px_inc < width_q) ? XW'(px_inc) : XW'(width_q - WW'(1));
	assign ky     = (py_inc < height_q) ? YW'(py_inc) : YW'(height_q - HW'(1));

	// read order: top left, top right, bottom left, bottom right
	assign rd_x    = rd_cnt_q[0] ? kx_q : px_q;
	assign rd_y    = rd_cnt_q[1] ? ky_q : py_q;
	assign rd_addr = AW'(AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x));

	buc_ram #(.DEPTH(DEPTH), .AW(AW), .DW(PIX_W)) u_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (ld_addr),
		.wdata (in_pl.pixel_in),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DIV) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_xfer) begin
			ox_q <= in_pl.out_x;
			oy_q <= in_pl.out_y;
		end
		if (state_q == ST_CHECK) begin
			sq_q <= SQW'(scale_q) * SQW'(scale_q);
			if (oor) begin
				res_pix_q <= '0;
				res_oor_q <= 1'b1;
			end
		end
		if (state_q == ST_DIV) begin
			px_q  <= px;
			py_q  <= py;
			kx_q  <= kx;
			ky_q  <= ky;
			wx0_q <= scale_q - x_rem;
			wx1_q <= x_rem;
			wy0_q <= scale_q - y_rem;
			wy1_q <= y_rem;
			acc_q <= '0;
		end
		k_s1 <= rd_cnt_q[1:0];
		k_s2 <= k_s1;
		pv_s2 <= PVW'(rd_data) * PVW'(k_s1[0] ? wx1_q : wx0_q);
		if (valid_s2) begin
			acc_q <= acc_q + ACCW'(pv_s2) * ACCW'(k_s2[1] ? wy1_q : wy0_q);
		end
		if ((state_q == ST_NORM) && !n_busy) begin
			res_pix_q <= (n_quo > ACCW'(PIX_MAX)) ? PIX_W'(PIX_MAX) : PIX_W'(n_quo);
			res_oor_q <= 1'b0;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_pix_q <= res_pix_q;
			out_oor_q <= res_oor_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tuser  = out_oor_q;

endmodule

[hw/rtl/buc_ram.sv]
// pixel store: one write port, one read port, registered read data
// no dependencies
module buc_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/buc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on buc_pkg for default widths
module buc_div #(
	parameter int NUM_W = buc_pkg::COORD_W,
	parameter int DEN_W = buc_pkg::SCALE_CFG_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[hw/rtl/buc_checker.sv]
// port-level checks of the bilinear integer upscaler, bound to the top level
// depends on buc_pkg and assert_macros.svh
`include "assert_macros.svh"

module buc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       s_axis_tuser,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [buc_pkg::PIX_W-1:0] m_axis_tdata,
	input logic                       m_axis_tuser
);

	import buc_pkg::*;

	// out of range results carry a zero pixel
	`ASSERT_AT(a_oor_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "out of range result with nonzero pixel")

	// a stalled result holds
	`ASSERT_AT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// a query transfer occupies the block
	`ASSERT_NEVER(a_query_busy, clk, arst_n, $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY)) && s_axis_tready, "ready straight after a query")

	// loads stream back to back
	`ASSERT_AT(a_load_stream, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD) |=> s_axis_tready, "ready dropped after a load")

endmodule

bind bilinear_integer_upscaler buc_checker u_buc_checker (.*);
